// ----- hw/rtl/qrs_pkg.sv -----
// Shared constants and types of the quadratic root solver.
`default_nettype none
package qrs_pkg;
    localparam int COEF_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ROOT_W         = 36;

    typedef enum logic [1:0] {
        KIND_NONQUAD = 2'd0,
        KIND_NOREAL  = 2'd1,
        KIND_SINGLE  = 2'd2,
        KIND_TWO     = 2'd3
    } kind_t;
endpackage
`default_nettype wire

// ----- hw/rtl/qrs_in_if.sv -----
// Coefficient word channel.
`default_nettype none
interface qrs_in_if #(parameter int COEF_WIDTH = 16);
    logic                         valid;
    logic                         ready;
    logic signed [COEF_WIDTH-1:0] coef_a;
    logic signed [COEF_WIDTH-1:0] coef_b;
    logic signed [COEF_WIDTH-1:0] coef_c;
    modport source (output valid, coef_a, coef_b, coef_c, input ready);
    modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/qrs_out_if.sv -----
// Root word channel.
`default_nettype none
interface qrs_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         root_kind;
    logic signed [35:0] root_plus;
    logic signed [35:0] root_minus;
    modport source (output valid, root_kind, root_plus, root_minus, input ready);
    modport sink (input valid, root_kind, root_plus, root_minus, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/qrs_delta.sv -----
// Discriminant stages: products, delta, classification and operand prep.
`default_nettype none
module qrs_delta import qrs_pkg::*; #(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int DW  = 2 * COEF_WIDTH + 2,
    localparam int DNW = COEF_WIDTH + 1,
    localparam int NBW = COEF_WIDTH + 1 + FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_vld,
    input  logic signed [COEF_WIDTH-1:0]  a,
    input  logic signed [COEF_WIDTH-1:0]  b,
    input  logic signed [COEF_WIDTH-1:0]  c,
    output logic                          out_vld,
    output kind_t                         kind,
    output logic [DW-1:0]                 rad,
    output logic                          aneg,
    output logic [DNW-1:0]                den,
    output logic signed [NBW-1:0]         nb
);
    logic                           s1_vld_reg;
    logic signed [COEF_WIDTH-1:0]   s1_a_reg;
    logic signed [COEF_WIDTH-1:0]   s1_b_reg;
    logic signed [2*COEF_WIDTH-1:0] s1_bb_reg;
    logic signed [2*COEF_WIDTH-1:0] s1_ac_reg;

    logic signed [DW:0]             delta;
    logic signed [COEF_WIDTH:0]     a_ext;
    logic signed [COEF_WIDTH:0]     b_neg;
    logic [DNW-1:0]                 den_next;
    logic signed [NBW-1:0]          nb_next;
    kind_t                          kind_next;
    logic [DW-1:0]                  rad_next;

    logic                           vld_reg;
    kind_t                          kind_reg;
    logic [DW-1:0]                  rad_reg;
    logic                           aneg_reg;
    logic [DNW-1:0]                 den_reg;
    logic signed [NBW-1:0]          nb_reg;

    always_comb
    begin
        delta   = (DW+1)'(s1_bb_reg) - ((DW+1)'(s1_ac_reg) <<< 2);
        a_ext   = (COEF_WIDTH+1)'(s1_a_reg);
        b_neg   = -(COEF_WIDTH+1)'(s1_b_reg);
        den_next = (a_ext < 0) ? DNW'((-a_ext) <<< 1) : DNW'(a_ext <<< 1);
        nb_next  = NBW'(b_neg) <<< FRAC_BITS;
        rad_next = '0;
        if (s1_a_reg == '0)
        begin
            kind_next = KIND_NONQUAD;
        end
        else if (delta < 0)
        begin
            kind_next = KIND_NOREAL;
        end
        else if (delta == '0)
        begin
            kind_next = KIND_SINGLE;
        end
        else
        begin
            kind_next = KIND_TWO;
            rad_next  = delta[DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            vld_reg    <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= in_vld;
            vld_reg    <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_a_reg  <= a;
            s1_b_reg  <= b;
            s1_bb_reg <= b * b;
            s1_ac_reg <= a * c;
            kind_reg  <= kind_next;
            rad_reg   <= rad_next;
            aneg_reg  <= s1_a_reg[COEF_WIDTH-1];
            den_reg   <= den_next;
            nb_reg    <= nb_next;
        end
    end

    assign out_vld = vld_reg;
    assign kind    = kind_reg;
    assign rad     = rad_reg;
    assign aneg    = aneg_reg;
    assign den     = den_reg;
    assign nb      = nb_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/qrs_sqrt.sv -----
// Pipelined integer square root, one root bit per stage, with sideband.
`default_nettype none
module qrs_sqrt #(
    parameter int SW     = 33,
    parameter int SIDE_W = 8,
    localparam int RW    = 2 * SW,
    localparam int REMW  = SW + 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_vld,
    input  logic [RW-1:0]     rad,
    input  logic [SIDE_W-1:0] side,
    output logic              out_vld,
    output logic [SW-1:0]     root,
    output logic [SIDE_W-1:0] side_out
);
    logic              vld_reg  [0:SW];
    logic [RW-1:0]     rad_reg  [0:SW];
    logic [SW-1:0]     root_reg [0:SW];
    logic [REMW-1:0]   rem_reg  [0:SW];
    logic [SIDE_W-1:0] side_reg [0:SW];

    always_comb
    begin
        vld_reg[0]  = in_vld;
        rad_reg[0]  = rad;
        root_reg[0] = '0;
        rem_reg[0]  = '0;
        side_reg[0] = side;
    end

    for (genvar i = 0; i < SW; i++)
    begin : g_stage
        logic [REMW+1:0] t_rem;
        logic [REMW+1:0] trial;
        logic            ge;

        always_comb
        begin
            t_rem = {rem_reg[i], rad_reg[i][RW-1 -: 2]};
            trial = (REMW+2)'({root_reg[i], 2'b01});
            ge    = (t_rem >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rad_reg[i+1]  <= rad_reg[i] << 2;
                root_reg[i+1] <= {root_reg[i][SW-2:0], ge};
                rem_reg[i+1]  <= ge ? REMW'(t_rem - trial) : REMW'(t_rem);
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_vld  = vld_reg[SW];
    assign root     = root_reg[SW];
    assign side_out = side_reg[SW];
endmodule
`default_nettype wire

// ----- hw/rtl/qrs_div.sv -----
// Pipelined dual restoring divider with sign fix, clamp and output register.
`default_nettype none
module qrs_div import qrs_pkg::*; #(
    parameter int NW   = 35,
    parameter int DNW  = 17,
    localparam int NMW = NW - 1,
    localparam int CMPW = (NMW + 1 > ROOT_W + 1) ? NMW + 1 : ROOT_W + 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     in_vld,
    input  kind_t                    kind,
    input  logic                     aneg,
    input  logic [DNW-1:0]           den,
    input  logic signed [NW-1:0]     np,
    input  logic signed [NW-1:0]     nm,
    output logic                     out_vld,
    output kind_t                    kind_out,
    output logic signed [ROOT_W-1:0] plus,
    output logic signed [ROOT_W-1:0] minus
);
    localparam logic signed [CMPW-1:0] OMAX = {{(CMPW-ROOT_W+1){1'b0}}, {(ROOT_W-1){1'b1}}};
    localparam logic signed [CMPW-1:0] OMIN = {{(CMPW-ROOT_W+1){1'b1}}, {(ROOT_W-1){1'b0}}};

    logic            vld_reg  [0:NMW];
    kind_t           kind_reg [0:NMW];
    logic [DNW-1:0]  den_reg  [0:NMW];
    logic [NMW-1:0]  num_reg  [0:NMW][0:1];
    logic [DNW-1:0]  rem_reg  [0:NMW][0:1];
    logic            neg_reg  [0:NMW][0:1];

    logic                     o_vld_reg;
    kind_t                    o_kind_reg;
    logic signed [ROOT_W-1:0] o_plus_reg;
    logic signed [ROOT_W-1:0] o_minus_reg;

    function automatic logic signed [ROOT_W-1:0] fix(input logic [NMW-1:0] q,
                                                     input logic neg);
        logic signed [CMPW-1:0] v;
        v = neg ? -$signed(CMPW'(q)) : $signed(CMPW'(q));
        if (v > OMAX)
        begin
            v = OMAX;
        end
        if (v < OMIN)
        begin
            v = OMIN;
        end
        return v[ROOT_W-1:0];
    endfunction

    logic signed [NW-1:0] num_in [0:1];
    assign num_in[0] = np;
    assign num_in[1] = nm;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind_reg[0] <= kind;
            den_reg[0]  <= den;
        end
    end

    for (genvar j = 0; j < 2; j++)
    begin : g_lane_in
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                num_reg[0][j] <= num_in[j][NW-1] ? NMW'(-num_in[j]) : NMW'(num_in[j]);
                rem_reg[0][j] <= '0;
                neg_reg[0][j] <= num_in[j][NW-1] ^ aneg;
            end
        end
    end

    for (genvar k = 0; k < NMW; k++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                kind_reg[k+1] <= kind_reg[k];
                den_reg[k+1]  <= den_reg[k];
            end
        end

        for (genvar j = 0; j < 2; j++)
        begin : g_lane
            logic [DNW:0] t;
            logic         ge;

            always_comb
            begin
                t  = {rem_reg[k][j], num_reg[k][j][NMW-1]};
                ge = (t >= {1'b0, den_reg[k]});
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    num_reg[k+1][j] <= {num_reg[k][j][NMW-2:0], ge};
                    rem_reg[k+1][j] <= ge ? DNW'(t - {1'b0, den_reg[k]}) : DNW'(t);
                    neg_reg[k+1][j] <= neg_reg[k][j];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            o_vld_reg <= vld_reg[NMW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_kind_reg <= kind_reg[NMW];
            if (kind_reg[NMW] == KIND_SINGLE || kind_reg[NMW] == KIND_TWO)
            begin
                o_plus_reg  <= fix(num_reg[NMW][0], neg_reg[NMW][0]);
                o_minus_reg <= fix(num_reg[NMW][1], neg_reg[NMW][1]);
            end
            else
            begin
                o_plus_reg  <= '0;
                o_minus_reg <= '0;
            end
        end
    end

    assign out_vld  = o_vld_reg;
    assign kind_out = o_kind_reg;
    assign plus     = o_plus_reg;
    assign minus    = o_minus_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/quadratic_root_solver_core.sv -----
// Top level of the quadratic root solver.
// Takes one coefficient word per cycle while the pipeline is not held and returns one
// root word per word, in order. A word passes through the delta stages, then the
// one-bit-per-stage square root and divider pipelines and the divider's output register.
// The whole pipeline holds while a finished word is not taken.
`default_nettype none
module quadratic_root_solver_core import qrs_pkg::*; #(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    qrs_in_if.sink    coef_in,
    qrs_out_if.source root_out
);
    localparam int DW     = 2 * COEF_WIDTH + 2;
    localparam int DNW    = COEF_WIDTH + 1;
    localparam int NBW    = COEF_WIDTH + 1 + FRAC_BITS;
    localparam int SW     = COEF_WIDTH + 1 + FRAC_BITS;
    localparam int RW     = 2 * SW;
    localparam int NW     = SW + 2;
    localparam int SIDE_W = 2 + 1 + DNW + NBW;

    logic                  adv;
    logic                  d_vld;
    kind_t                 d_kind;
    logic [DW-1:0]         d_rad;
    logic                  d_aneg;
    logic [DNW-1:0]        d_den;
    logic signed [NBW-1:0] d_nb;

    logic                  s_vld;
    logic [SW-1:0]         s_root;
    logic [SIDE_W-1:0]     s_side;
    kind_t                 s_kind;
    logic                  s_aneg;
    logic [DNW-1:0]        s_den;
    logic signed [NBW-1:0] s_nb;
    logic signed [NW-1:0]  np;
    logic signed [NW-1:0]  nm;

    logic                  o_vld;
    kind_t                 o_kind;

    assign adv           = !o_vld || root_out.ready;
    assign coef_in.ready = adv;

    qrs_delta #(.COEF_WIDTH(COEF_WIDTH), .FRAC_BITS(FRAC_BITS)) u_delta (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(coef_in.valid),
        .a(coef_in.coef_a), .b(coef_in.coef_b), .c(coef_in.coef_c),
        .out_vld(d_vld), .kind(d_kind), .rad(d_rad), .aneg(d_aneg),
        .den(d_den), .nb(d_nb)
    );

    qrs_sqrt #(.SW(SW), .SIDE_W(SIDE_W)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(d_vld),
        .rad(RW'(d_rad) << (2 * FRAC_BITS)),
        .side({d_kind, d_aneg, d_den, d_nb}),
        .out_vld(s_vld), .root(s_root), .side_out(s_side)
    );

    always_comb
    begin
        s_kind = kind_t'(s_side[SIDE_W-1 -: 2]);
        s_aneg = s_side[DNW+NBW];
        s_den  = s_side[NBW +: DNW];
        s_nb   = s_side[NBW-1:0];
        np     = NW'(s_nb) + $signed(NW'(s_root));
        nm     = NW'(s_nb) - $signed(NW'(s_root));
    end

    qrs_div #(.NW(NW), .DNW(DNW)) u_div (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(s_vld),
        .kind(s_kind), .aneg(s_aneg), .den(s_den), .np(np), .nm(nm),
        .out_vld(o_vld), .kind_out(o_kind),
        .plus(root_out.root_plus), .minus(root_out.root_minus)
    );

    assign root_out.valid     = o_vld;
    assign root_out.root_kind = o_kind;
endmodule
`default_nettype wire

// ----- tb/sv/quadratic_root_solver_core_test.sv -----
// Self-checking testbench for the quadratic root solver core.
`timescale 1ns / 1ps
module quadratic_root_solver_core_test;
    import qrs_pkg::*;

    typedef struct {
        kind_t              kind;
        logic signed [35:0] plus;
        logic signed [35:0] minus;
    } roots_t;

    class root_scoreboard;
        roots_t pending_roots[$];
        int     errors;

        function new();
            errors = 0;
        endfunction

        function logic signed [35:0] clamp36(longint v);
            longint hi;
            longint lo;
            hi = 64'sd34359738367;
            lo = -64'sd34359738368;
            if (v > hi) v = hi;
            if (v < lo) v = lo;
            return v[35:0];
        endfunction

        function roots_t predict(logic signed [15:0] ca, logic signed [15:0] cb,
                                 logic signed [15:0] cc);
            roots_t r;
            longint a;
            longint b;
            longint c;
            longint delta;
            longint s;
            longint nb;
            longint den;
            logic [127:0] scaled;
            logic [127:0] trial;
            a = ca;
            b = cb;
            c = cc;
            r.kind = KIND_NONQUAD;
            r.plus = '0;
            r.minus = '0;
            if (a == 0) return r;
            delta = b * b - 4 * a * c;
            if (delta < 0)
            begin
                r.kind = KIND_NOREAL;
                return r;
            end
            r.kind = (delta == 0) ? KIND_SINGLE : KIND_TWO;
            scaled = 128'(delta) << 32;
            s = 0;
            for (int bit_i = 63; bit_i >= 0; bit_i--)
            begin
                trial = 128'(s | (64'sd1 << bit_i));
                if (trial * trial <= scaled) s = s | (64'sd1 << bit_i);
            end
            nb = -b * 65536;
            den = 2 * a;
            r.plus = clamp36((nb + s) / den);
            r.minus = clamp36((nb - s) / den);
            return r;
        endfunction

        function void note_coefs(logic signed [15:0] ca, logic signed [15:0] cb,
                                 logic signed [15:0] cc);
            pending_roots.push_back(predict(ca, cb, cc));
        endfunction

        function void check_roots(logic [1:0] kind, logic signed [35:0] plus,
                                  logic signed [35:0] minus);
            roots_t e;
            if (pending_roots.size() == 0)
            begin
                $display("%0t: unexpected word kind=%0d plus=%0d minus=%0d",
                         $time, kind, plus, minus);
                errors++;
                return;
            end
            e = pending_roots.pop_front();
            if (kind !== e.kind)
            begin
                $display("%0t: root_kind expected %0d actual %0d", $time, e.kind, kind);
                errors++;
            end
            if (plus !== e.plus)
            begin
                $display("%0t: root_plus expected %0d actual %0d", $time, e.plus, plus);
                errors++;
            end
            if (minus !== e.minus)
            begin
                $display("%0t: root_minus expected %0d actual %0d", $time, e.minus, minus);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   no_idle = 1'b0;
    root_scoreboard sb = new();

    qrs_in_if #(.COEF_WIDTH(16)) cin();
    qrs_out_if rout();

    quadratic_root_solver_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .coef_in (cin),
        .root_out(rout)
    );

    always #6 clk = ~clk;

    initial
    begin
        cin.valid = 1'b0;
        cin.coef_a = '0;
        cin.coef_b = '0;
        cin.coef_c = '0;
        rout.ready = 1'b0;
    end

    task automatic send_coefs(logic signed [15:0] ca, logic signed [15:0] cb,
                              logic signed [15:0] cc);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            cin.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cin.valid <= 1'b1;
        cin.coef_a <= ca;
        cin.coef_b <= cb;
        cin.coef_c <= cc;
        do @(posedge clk); while (!cin.ready);
        sb.note_coefs(ca, cb, cc);
        @(negedge clk);
    endtask

    task automatic send_random();
        int mode;
        int m;
        int n;
        mode = $urandom_range(0, 9);
        if (mode < 4)
            send_coefs($urandom, $urandom, $urandom);
        else if (mode < 6)
            send_coefs($urandom_range(0, 64) - 32, $urandom_range(0, 64) - 32,
                       $urandom_range(0, 64) - 32);
        else if (mode < 8)
        begin
            m = $urandom_range(0, 180) - 90;
            n = $urandom_range(0, 180) - 90;
            send_coefs(m * m * (($urandom_range(0, 1) != 0) ? 1 : -1), 2 * m * n, n * n);
        end
        else if (mode == 8)
        begin
            m = $urandom_range(0, 180) - 90;
            n = $urandom_range(0, 180) - 90;
            send_coefs(-m * m, 2 * m * n, -n * n);
        end
        else
            send_coefs(0, $urandom, $urandom);
    endtask

    initial
    begin
        int stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                rout.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rout.ready <= 1'b1;
            do @(posedge clk); while (!rout.valid);
            sb.check_roots(rout.root_kind, rout.root_plus, rout.root_minus);
            @(negedge clk);
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        send_coefs(0, 0, 0);
        send_coefs(0, -32768, 32767);
        send_coefs(1, 0, 1);
        send_coefs(32767, 0, 32767);
        send_coefs(1, 2, 1);
        send_coefs(-1, 0, 0);
        send_coefs(16384, -32768, 16384);
        send_coefs(1, 0, -1);
        send_coefs(-32768, 32767, 32767);
        send_coefs(32767, -32768, -32768);
        send_coefs(-32768, -32768, -32768);
        send_coefs(32767, 32767, 32767);
        send_coefs(-32768, 0, 32767);
        send_coefs(1, -32768, 0);
        send_coefs(-1, 32767, 0);
        send_coefs(3, -7, 2);
        send_coefs(-5, 3, 11);
        send_coefs(1, -1, -32768);
        send_coefs(-1, -1, 1);
        send_coefs(16'sh5555, 16'shAAAA, 16'sh5555);
        for (int i = 0; i < 1300; i++)
        begin
            if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
            send_random();
        end
        cin.valid <= 1'b0;
        no_idle = 1'b0;
        wait (sb.pending_roots.size() == 0);
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending_roots.size() == 0)
            $display("quadratic_root_solver_core: match");
        else
            $display("quadratic_root_solver_core: mismatch");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("quadratic_root_solver_core: mismatch");
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/qrs_pkg.sv
hw/rtl/qrs_in_if.sv
hw/rtl/qrs_out_if.sv
hw/rtl/qrs_delta.sv
hw/rtl/qrs_sqrt.sv
hw/rtl/qrs_div.sv
hw/rtl/quadratic_root_solver_core.sv
tb/sv/quadratic_root_solver_core_test.sv
